// ----- rtl/oprq_pkg.sv -----
package oprq_pkg;

  localparam int MaxTasks = 64;
  localparam int Levels = 140;
  localparam int IdW = 6;
  localparam int PrioW = 8;
  localparam int SlotW = 9;
  localparam int LvlW = 8;
  localparam int QuantW = 12;
  localparam int CntW = 7;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_DISPATCH = 2'd1,
    FUNC_REQUEUE  = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ENQ_RD,
    ST_ENQ_WR,
    ST_SCAN,
    ST_DEQ_RD,
    ST_DEQ_WR,
    ST_PRIO_RD,
    ST_PRIO_WAIT,
    ST_OUT
  } state_t;

  function automatic logic [QuantW-1:0] quantum_of(input logic [PrioW-1:0] p);
    logic [PrioW-1:0] d;
    begin
      d = PrioW'(Levels) - p;
      if (p >= PrioW'(140)) begin
        quantum_of = '0;
      end else if (p < PrioW'(100)) begin
        quantum_of = QuantW'({d, 4'b0}) + QuantW'({d, 2'b0});
      end else begin
        quantum_of = QuantW'({d, 2'b0}) + QuantW'(d);
      end
    end
  endfunction

endpackage

// ----- rtl/o1_priority_run_queue_top.sv -----
// Channel  Dir  tuser      tdata (low bit up)
// s_axis   in   func[1:0]  task_id[5:0] prio_in[13:6] wait_ticks[29:14] run_span[45:30]
// m_axis   out  status[0]  task_out[5:0] prio_out[13:6] quantum[25:14] repeat_res[26]
//                          swapped[27]
// One item at a time, accepted only in idle. Insert and requeue read the priority, then
// enqueue; a requeue that updates the priority first runs a 20-step serial divider.
// Dispatch scans the 64-bit bitmap words one by one (1 to 3) before it dequeues; an item
// that changes nothing goes straight to the result.
// Reset is synchronous; the RAMs need no clearing. The result register holds while
// m_axis_tready is low and the next item waits in the input.
module o1_priority_run_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // func
  input  logic [47:0] s_axis_tdata,  // task_id, prio_in, wait_ticks, run_span
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,  // status
  output logic [31:0] m_axis_tdata   // task_out, prio_out, quantum, repeat_res, swapped
);
  import oprq_pkg::*;

  // Memories.
  logic [IdW-1:0]   link_mem [MaxTasks];
  logic [PrioW-1:0] prio_mem [MaxTasks];
  logic [IdW-1:0]   head_mem [2*Levels];
  logic [IdW-1:0]   tail_mem [2*Levels];

  logic [SlotW-1:0] slot;
  logic [IdW-1:0]   head_rd, tail_rd, link_rd;
  logic [PrioW-1:0] prio_rd;
  logic [IdW-1:0]   link_addr, prio_addr;
  logic             head_we, tail_we, link_we, prio_we;
  logic [IdW-1:0]   head_wd, tail_wd, link_wd;
  logic [PrioW-1:0] prio_wd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[slot] <= head_wd;
    if (tail_we) tail_mem[slot] <= tail_wd;
    if (link_we) link_mem[link_addr] <= link_wd;
    if (prio_we) prio_mem[prio_addr] <= prio_wd;
    head_rd <= head_mem[slot];
    tail_rd <= tail_mem[slot];
    link_rd <= link_mem[link_addr];
    prio_rd <= prio_mem[prio_addr];
  end

  // Control state.
  state_t           state, state_next;
  logic [2*Levels-1:0] ne;
  logic [2*Levels-1:0] nev;
  logic [CntW-1:0]  cnt0, cnt1;
  logic             act;
  logic [IdW-1:0]   last_task;
  logic             last_valid, rep_pend;
  logic [MaxTasks-1:0] queued;

  // Item registers.
  func_t            func;
  logic [IdW-1:0]   tid;
  logic [PrioW-1:0] pin, prio;
  logic [15:0]      span;
  logic [19:0]      wait10;
  logic             upd;
  logic [1:0]       word;
  logic [SlotW-1:0] sslot;
  logic             o_status, o_rep, o_swp;
  logic [IdW-1:0]   o_task;
  logic [PrioW-1:0] o_prio;

  logic             div_start, div_busy;
  logic [19:0]      quo;

  oprq_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(wait10), .den(span), .busy(div_busy), .quo(quo)
  );

  assign nev = ne;
  assign s_axis_tready = (state == ST_IDLE);
  assign upd = rep_pend && last_valid && (last_task == tid);

  // Scan one 64-bit word of the active bank per cycle.
  logic [63:0]      wbits;
  logic             wfound;
  logic [5:0]       wpos;
  logic [SlotW-1:0] base, wslot;
  always_comb begin
    base = act ? SlotW'(Levels) : '0;
    wslot = base + {1'b0, word, 6'b0};
    wbits = '0;
    for (int i = 0; i < 64; i++) begin
      if ((SlotW'(i) + {1'b0, word, 6'b0}) < SlotW'(Levels)) begin
        wbits[i] = ne[wslot + SlotW'(i)];
      end
    end
    wfound = 1'b0;
    wpos = '0;
    for (int i = 63; i >= 0; i--) begin
      if (wbits[i]) begin
        wfound = 1'b1;
        wpos = 6'(i);
      end
    end
  end

  // Requeue priority: p - bonus + 5 clamped to [100,139].
  logic [PrioW-1:0] newp;
  logic [20:0]      newv;
  always_comb begin
    newv = 21'(prio) + 21'd5 - ((span != 16'd0) ? {1'b0, quo} : 21'd0);
    if (span != 16'd0 && quo >= 20'(prio) + 20'd5) begin
      newp = 8'd100;
    end else if (newv < 21'd100) begin
      newp = 8'd100;
    end else if (newv > 21'd139) begin
      newp = 8'd139;
    end else begin
      newp = newv[PrioW-1:0];
    end
  end

  logic enq_bank;
  assign enq_bank = ~act;
  logic [SlotW-1:0] enq_slot;
  assign enq_slot = (enq_bank ? SlotW'(Levels) : '0) + SlotW'(prio);

  always_comb begin
    state_next = state;
    slot = sslot;
    link_addr = tid;
    prio_addr = tid;
    head_we = 1'b0; tail_we = 1'b0; link_we = 1'b0; prio_we = 1'b0;
    head_wd = tid; tail_wd = tid; link_wd = tid; prio_wd = prio;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        prio_addr = s_axis_tdata[5:0];
        if (s_axis_tvalid) state_next = ST_PRIO_RD;
      end
      ST_PRIO_RD: state_next = ST_PRIO_WAIT;
      ST_PRIO_WAIT: begin
        state_next = ST_OUT;
        if (func == FUNC_DISPATCH) begin
          state_next = ST_SCAN;
        end else if ((func == FUNC_INSERT || func == FUNC_REQUEUE) && !queued[tid]) begin
          if (func == FUNC_REQUEUE && upd) begin
            div_start = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_ENQ_RD;
          end
        end
      end
      ST_DIV: if (!div_busy) state_next = ST_ENQ_RD;
      ST_ENQ_RD: begin
        slot = enq_slot;
        prio_we = 1'b1;
        state_next = ST_ENQ_WR;
      end
      ST_ENQ_WR: begin
        slot = enq_slot;
        link_addr = tail_rd;
        link_we = nev[enq_slot];
        head_we = !nev[enq_slot];
        tail_we = 1'b1;
        state_next = ST_OUT;
      end
      ST_SCAN: begin
        if (wfound) begin
          slot = wslot + SlotW'(wpos);
          state_next = ST_DEQ_RD;
        end else if (word == 2'd2) begin
          state_next = ST_OUT;
        end
      end
      ST_DEQ_RD: begin
        link_addr = head_rd;
        prio_addr = head_rd;
        state_next = ST_DEQ_WR;
      end
      ST_DEQ_WR: begin
        head_we = (head_rd != tail_rd);
        head_wd = link_rd;
        link_addr = head_rd;
        state_next = ST_OUT;
      end
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ne <= '0;
      cnt0 <= '0; cnt1 <= '0;
      act <= 1'b0;
      last_valid <= 1'b0;
      last_task <= '0;
      rep_pend <= 1'b0;
      queued <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          func <= func_t'(s_axis_tuser);
          tid <= s_axis_tdata[5:0];
          pin <= s_axis_tdata[13:6];
          wait10 <= {1'b0, s_axis_tdata[29:14], 3'b0} + {3'b0, s_axis_tdata[29:14], 1'b0};
          span <= s_axis_tdata[45:30];
          o_status <= 1'b0; o_rep <= 1'b0; o_swp <= 1'b0;
          o_task <= '0; o_prio <= '0;
          word <= '0;
        end
        ST_PRIO_WAIT: begin
          if (func == FUNC_DISPATCH) begin
            if (((act ? cnt1 : cnt0) == '0) && ((act ? cnt0 : cnt1) != '0)) begin
              act <= ~act;
              o_swp <= 1'b1;
            end
          end else if (func == FUNC_INSERT || func == FUNC_REQUEUE) begin
            o_task <= tid;
            if (queued[tid]) o_prio <= prio_rd;
            prio <= (func == FUNC_INSERT) ?
                    ((pin > 8'd139) ? 8'd139 : pin) : prio_rd;
            if (func == FUNC_REQUEUE && !queued[tid]) rep_pend <= 1'b0;
          end
        end
        ST_ENQ_RD: begin
          o_prio <= prio;
          if (enq_bank) cnt1 <= cnt1 + 1'b1; else cnt0 <= cnt0 + 1'b1;
          queued[tid] <= 1'b1;
        end
        ST_ENQ_WR: ne[enq_slot] <= 1'b1;
        ST_SCAN: begin
          sslot <= wslot + SlotW'(wpos);
          word <= word + 2'd1;
          if (!wfound && word == 2'd2) o_status <= 1'b1;
        end
        ST_DEQ_RD: begin
          o_task <= head_rd;
          o_rep <= last_valid && last_task == head_rd;
          rep_pend <= last_valid && last_task == head_rd;
          last_task <= head_rd;
          last_valid <= 1'b1;
          queued[head_rd] <= 1'b0;
          if (head_rd == tail_rd) ne[sslot] <= 1'b0;
          if (act) begin
            if (cnt1 != '0) cnt1 <= cnt1 - 1'b1;
          end else if (cnt0 != '0) cnt0 <= cnt0 - 1'b1;
        end
        ST_DEQ_WR: o_prio <= prio_rd;
        default: ;
      endcase
      if (state == ST_DIV && !div_busy) prio <= newp;
    end
  end

  // Only a dispatch that finds a task reports a quantum; every other item gives zero.
  logic [QuantW-1:0] o_quant;
  assign o_quant = (func == FUNC_DISPATCH && !o_status) ? quantum_of(o_prio) : '0;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tuser = o_status;
  assign m_axis_tdata = {4'b0, o_swp, o_rep, o_quant, o_prio, o_task};
endmodule

// ----- rtl/oprq_div.sv -----
module oprq_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] num,
  input  logic [15:0] den,
  output logic        busy,
  output logic [19:0] quo
);
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic [16:0] trial;
  logic [19:0] num_shift;

  assign trial = {rem[15:0], num_shift[19]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'd20;
      rem <= '0;
      num_shift <= num;
      quo <= '0;
    end else if (busy) begin
      num_shift <= {num_shift[18:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[18:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[18:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
